>>> sv/skt_pkg.sv
// Shared constants, codes and types of the sorted key table.
package skt_pkg;

  // Table geometry and field widths.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned KEY_W = 64;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned LIM_W = 7;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd65;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_PUT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_KEY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_POS = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_REPLACED = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_FOUND    = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_MISSING  = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] STATUS_BADPOS   = 3'd5;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PAY_W-1:0] pay_t;

  // Per-cell update controls for one resolve cycle.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load_key;
    logic load_pay;
  } cell_ctl_t;

endpackage

>>> sv/skt_cell.sv
// One table cell: holds a key and payload, compares against the search key, shifts to neighbors.
module skt_cell import skt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmp_en_i,
  input  logic      occupied_i,
  input  key_t      search_key_i,
  input  key_t      new_key_i,
  input  pay_t      new_pay_i,
  input  cell_ctl_t ctl_i,
  input  key_t      prev_key_i,
  input  pay_t      prev_pay_i,
  input  key_t      next_key_i,
  input  pay_t      next_pay_i,
  output key_t      key_o,
  output pay_t      pay_o,
  output logic      lt_o,
  output logic      eq_o
);

  key_t key_q;
  pay_t pay_q;
  logic lt_q;
  logic eq_q;

  // Key storage: load a new key or take a neighbor's on a shift.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_key) begin
      key_q <= new_key_i;
    end else if (ctl_i.shift_up) begin
      key_q <= prev_key_i;
    end else if (ctl_i.shift_down) begin
      key_q <= next_key_i;
    end
  end

  // Payload storage follows the same moves as the key.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_pay) begin
      pay_q <= new_pay_i;
    end else if (ctl_i.shift_up) begin
      pay_q <= prev_pay_i;
    end else if (ctl_i.shift_down) begin
      pay_q <= next_pay_i;
    end
  end

  // Signed compare against the incoming key, captured when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmp_en_i) begin
      lt_q <= occupied_i && ($signed(key_q) < $signed(search_key_i));
      eq_q <= occupied_i && (key_q == search_key_i);
    end
  end

  assign key_o = key_q;
  assign pay_o = pay_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

>>> sv/sorted_key_table.sv
// Top level of the sorted key table: cell row, position resolve, control and result register.
//
// The table holds up to 64 entries in ascending signed key order in a row of cells.
// For each request, at acceptance every cell compares its key with the search key in
// parallel and registers the flags; once the result register is free or being taken,
// the insertion point is found from the row of compare flags, the result is registered
// and the affected cells shift up or down one place at once. A new request is taken in
// the cycle after the result is produced, so only one request is in flight at a time;
// a result left waiting holds the block until it is taken. Configuration writes are
// taken in any cycle. Key and payload storage have no reset and need no clearing pass:
// only entries below the entry count are ever compared or read.
module sorted_key_table import skt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [LIM_W-1:0]         cfg_data_i,
  // Request channel.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [KEY_W-1:0]  search_key_i,
  input  logic [PAY_W-1:0]         new_payload_i,
  input  logic [IDX_W-1:0]         delete_position_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic [CNT_W-1:0]         entry_index_o,
  output logic [PAY_W-1:0]         read_payload_o,
  output logic [CNT_W-1:0]         entries_now_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic             state_q, state_d;
  logic [LIM_W-1:0] limit_q;
  logic [CNT_W-1:0] entry_count_q, entry_count_d;

  // Registered request.
  logic [MODE_W-1:0] mode_q;
  key_t              key_q;
  pay_t              pay_q;
  logic [IDX_W-1:0]  dpos_q;

  // Result register.
  logic              out_valid_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [CNT_W-1:0]  index_q, index_d;
  pay_t              rdata_q, rdata_d;

  logic accept;
  logic fire;

  // Cell row signals.
  key_t             key_vec [DEPTH];
  pay_t             pay_vec [DEPTH];
  cell_ctl_t        ctl_vec [DEPTH];
  logic [DEPTH-1:0] lt_vec;
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] first_vec;
  logic [DEPTH-1:0] occ_vec;

  // Resolve results.
  logic [CNT_W-1:0] pos;
  logic             hit;
  pay_t             hit_pay;
  logic             full;
  logic             pos_ok;
  logic             do_insert;
  logic             do_replace;
  logic             do_del_key;
  logic             do_del_pos;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign fire        = (state_q == S_BUSY) && (!out_valid_q || out_ready_i);

  // Row of cells; the ends take zero or their own contents on a shift.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    key_t prev_key, next_key;
    pay_t prev_pay, next_pay;

    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_pay = '0;
    end else begin : g_mid_prev
      assign prev_key = key_vec[i-1];
      assign prev_pay = pay_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_key = key_vec[i];
      assign next_pay = pay_vec[i];
    end else begin : g_mid_next
      assign next_key = key_vec[i+1];
      assign next_pay = pay_vec[i+1];
    end

    assign occ_vec[i] = CNT_W'(i) < entry_count_q;

    // A cell is the insertion point when it is the first one not below the key.
    if (i == 0) begin : g_edge0
      assign first_vec[i] = !lt_vec[i];
    end else begin : g_edge
      assign first_vec[i] = !lt_vec[i] && lt_vec[i-1];
    end

    // Per-cell controls, applied only in the resolve cycle.
    always_comb begin
      ctl_vec[i].shift_up   = fire && do_insert && !lt_vec[i] && !first_vec[i];
      ctl_vec[i].load_key   = fire && do_insert && first_vec[i];
      ctl_vec[i].load_pay   = fire && (do_insert || do_replace) && first_vec[i];
      ctl_vec[i].shift_down = fire && ((do_del_key && !lt_vec[i]) ||
                                       (do_del_pos && (IDX_W'(i) >= dpos_q)));
    end

    skt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_en_i     (accept),
      .occupied_i   (occ_vec[i]),
      .search_key_i (search_key_i),
      .new_key_i    (key_q),
      .new_pay_i    (pay_q),
      .ctl_i        (ctl_vec[i]),
      .prev_key_i   (prev_key),
      .prev_pay_i   (prev_pay),
      .next_key_i   (next_key),
      .next_pay_i   (next_pay),
      .key_o        (key_vec[i]),
      .pay_o        (pay_vec[i]),
      .lt_o         (lt_vec[i]),
      .eq_o         (eq_vec[i])
    );
  end

  // Encode the insertion point and pick the matching payload.
  always_comb begin
    pos     = '0;
    hit     = 1'b0;
    hit_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        pos = pos | CNT_W'(i);
      end
      if (first_vec[i] && eq_vec[i]) begin
        hit     = 1'b1;
        hit_pay = hit_pay | pay_vec[i];
      end
    end
    if (lt_vec[DEPTH-1]) begin
      pos = CNT_W'(DEPTH);
    end
  end

  assign full   = (({1'b0, entry_count_q} + (CNT_W+1)'(1)) >= (CNT_W+1)'(limit_q)) ||
                  (entry_count_q >= CNT_W'(DEPTH));
  assign pos_ok = CNT_W'(dpos_q) < entry_count_q;

  // Mode decode: result fields and the table update to apply.
  always_comb begin
    status_d      = STATUS_MISSING;
    index_d       = pos;
    rdata_d       = '0;
    do_insert     = 1'b0;
    do_replace    = 1'b0;
    do_del_key    = 1'b0;
    do_del_pos    = 1'b0;
    entry_count_d = entry_count_q;
    unique case (mode_q)
      MODE_PUT: begin
        if (hit) begin
          status_d   = STATUS_REPLACED;
          do_replace = 1'b1;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          status_d      = STATUS_INSERTED;
          do_insert     = 1'b1;
          entry_count_d = entry_count_q + CNT_W'(1);
        end
      end
      MODE_GET: begin
        if (hit) begin
          status_d = STATUS_FOUND;
          rdata_d  = hit_pay;
        end
      end
      MODE_DEL_KEY: begin
        if (entry_count_q == '0) begin
          status_d = STATUS_BADPOS;
          index_d  = '0;
        end else if (hit) begin
          status_d      = STATUS_FOUND;
          do_del_key    = 1'b1;
          entry_count_d = entry_count_q - CNT_W'(1);
        end
      end
      MODE_DEL_POS: begin
        if (entry_count_q == '0) begin
          status_d = STATUS_BADPOS;
          index_d  = '0;
        end else if (!pos_ok) begin
          status_d = STATUS_BADPOS;
          index_d  = CNT_W'(dpos_q);
        end else begin
          status_d      = STATUS_FOUND;
          index_d       = CNT_W'(dpos_q);
          do_del_pos    = 1'b1;
          entry_count_d = entry_count_q - CNT_W'(1);
        end
      end
      default: begin
        status_d = STATUS_MISSING;
      end
    endcase
  end

  // Sequencer: idle until a request, busy until its result is registered.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_BUSY;
        end
      end
      S_BUSY: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      limit_q       <= LIMIT_RESET;
      entry_count_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (fire) begin
        entry_count_q <= entry_count_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      key_q  <= search_key_i;
      pay_q  <= new_payload_i;
      dpos_q <= delete_position_i;
    end
  end

  // Result payload capture.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      index_q  <= index_d;
      rdata_q  <= rdata_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entry_index_o  = index_q;
  assign read_payload_o = rdata_q;
  assign entries_now_o  = entry_count_q;

  // The entry count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  // Compare flags form a prefix, so at most one cell is the insertion point.
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) |-> $onehot0(first_vec))
    else $error("more than one insertion point in the cell row");

  // An insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && do_insert) |=> (entry_count_q == $past(entry_count_q) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // A delete shrinks the table by exactly one entry.
  a_delete_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (do_del_key || do_del_pos)) |=>
      (entry_count_q == $past(entry_count_q) - CNT_W'(1)))
    else $error("delete did not remove one entry");

endmodule
